[src/fvm_pkg.sv]
`timescale 1ns / 1ps
package fvm_pkg;
   localparam logic [1:0] KIND_BYTE   = 2'd0;
   localparam logic [1:0] KIND_FIRST  = 2'd1;
   localparam logic [1:0] KIND_LOCATE = 2'd2;
   localparam logic [1:0] KIND_DECODE = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FEED      = 3'd1;
   localparam logic [2:0] ST_NO_BPB    = 3'd2;
   localparam logic [2:0] ST_FAT16_SZ  = 3'd3;
   localparam logic [2:0] ST_FAT12_CNT = 3'd4;
   localparam logic [2:0] ST_FAT16_CNT = 3'd5;
   localparam logic [2:0] ST_ZERO_DIV  = 3'd6;
   localparam logic [2:0] ST_UNMOUNTED = 3'd7;

   localparam logic [31:0] FAT12_LIMIT = 32'd4085;
   localparam logic [31:0] FAT16_LIMIT = 32'd65525;
   localparam logic [31:0] ENTRY_MASK  = 32'h0FFF_FFFF;

   // serial divider / multiplier request
   typedef struct packed {
      logic        start;
      logic        is_div;
      logic [31:0] a;
      logic [15:0] b;
   } op_req_type;
endpackage

[src/fvm_serial_unit.sv]
`timescale 1ns / 1ps
// Bit-serial unit: restoring divide (32/16) or shift-add multiply (32x16, low 32).
// One bit per cycle.
module fvm_serial_unit (
   input  logic               clock,
   input  logic               reset,
   input  fvm_pkg::op_req_type req,
   output logic               done,
   output logic [31:0]        quot,
   output logic [31:0]        rem
);
   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        div_ff, div_in;
   logic [31:0] a_ff, a_in;
   logic [31:0] r_ff, r_in;
   logic [15:0] b_ff, b_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [31:0] bsh;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      a_in    = a_ff;
      r_in    = r_ff;
      b_in    = b_ff;
      done_in = 1'b0;
      trial   = {r_ff, a_ff[31]} - {17'd0, b_ff};
      bsh     = {16'd0, b_ff} << cnt_ff[4:0];
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         div_in  = req.is_div;
         a_in    = req.a;
         b_in    = req.b;
         r_in    = 32'd0;
      end else if (busy_ff) begin
         if (div_ff) begin
            if (!trial[32]) begin
               r_in = trial[31:0];
               a_in = {a_ff[30:0], 1'b1};
            end else begin
               r_in = {r_ff[30:0], a_ff[31]};
               a_in = {a_ff[30:0], 1'b0};
            end
         end else begin
            // multiplier a, multiplicand b shifted by bit position
            if (a_ff[cnt_ff[4:0]]) r_in = r_ff + bsh;
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      div_ff <= div_in;
      a_ff   <= a_in;
      r_ff   <= r_in;
      b_ff   <= b_in;
   end

   assign done = done_ff;
   assign quot = div_ff ? a_ff : r_ff;
   assign rem  = r_ff;
endmodule

[src/fat32_volume_mount_and_cluster_map.sv]
`timescale 1ns / 1ps
// FAT32 volume mount and cluster map.
// Command channel: an item transfers when start is high and busy is low.
// Sector bytes (kind 0) are taken one per cycle while busy is low; a byte that is not
// the last of its sector gives no result. Feed sector 0 first; if it is an MBR the
// block answers status 1 with the partition sector to feed next, in the next cycle.
// At the end of a boot sector one shared bit-serial unit runs up to three operations
// back to back: FAT copies times FAT size, the cluster count division and the root
// sector multiply. The mount result comes after the third; a failed FAT16 size or zero
// cluster size check answers after the first, a rejected cluster count after the second.
// Cluster first-sector queries (nonzero cluster) and FAT locate run on the serial unit;
// root queries, FAT word decode and the error answers come in the next cycle.
// busy stays high while an operation runs; one item is in flight at a time.
// Each result is shown for one cycle with rsp_valid; the receiver cannot stall.
// Reset clears all captured geometry and leaves the block unmounted.
module fat32_volume_mount_and_cluster_map (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [8:0]  req_byte_index,
   input  logic [7:0]  req_byte_value,
   input  logic        req_last_byte,
   input  logic [27:0] req_cluster_number,
   input  logic [31:0] req_fat_word,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_sector_number,
   output logic [15:0] rsp_byte_offset,
   output logic [31:0] rsp_start_of_fat,
   output logic [31:0] rsp_first_data_sector,
   output logic [31:0] rsp_first_root_sector,
   output logic [7:0]  rsp_sectors_per_cluster,
   output logic [15:0] rsp_bytes_per_sector,
   output logic [27:0] rsp_next_cluster
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CNT   = 3'd1;
   localparam logic [2:0] S_ROOT  = 3'd2;
   localparam logic [2:0] S_FIRST = 3'd3;
   localparam logic [2:0] S_LOC   = 3'd4;
   localparam logic [2:0] S_META  = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic        phase_ff, phase_in;
   logic        mounted_ff, mounted_in;
   logic [31:0] part_ff, part_in;
   logic [7:0]  jump_ff, jump_in;
   logic [31:0] mbr_ff, mbr_in;
   logic [15:0] bps_ff, bps_in;
   logic [7:0]  spc_ff, spc_in;
   logic [15:0] rsv_ff, rsv_in;
   logic [7:0]  nfat_ff, nfat_in;
   logic [15:0] tsml_ff, tsml_in;
   logic [31:0] tlrg_ff, tlrg_in;
   logic [15:0] fsml_ff, fsml_in;
   logic [31:0] flrg_ff, flrg_in;
   logic [31:0] root_ff, root_in;
   logic [31:0] fat_ff, fat_in;
   logic [31:0] data_ff, data_in;
   logic [31:0] rts_ff, rts_in;
   logic [31:0] meta_ff, meta_in;
   logic        vld_ff, vld_in;
   logic [2:0]  st_ff, st_in;
   logic [31:0] sec_ff, sec_in;
   logic [15:0] off_ff, off_in;
   logic [27:0] nxt_ff, nxt_in;
   logic        wait_ff, wait_in;

   fvm_pkg::op_req_type op;
   logic        op_done;
   logic [31:0] op_q, op_r;
   logic [31:0] total;
   logic [31:0] data_off;

   fvm_serial_unit u_serial (
      .clock(clock), .reset(reset), .req(op),
      .done(op_done), .quot(op_q), .rem(op_r)
   );

   assign total = (tsml_ff != 16'd0) ? {16'd0, tsml_ff} : tlrg_ff;
   assign data_off = meta_ff + part_ff;

   always_comb begin
      logic [8:0] p;
      logic [7:0] b;
      logic       hj;
      p = req_byte_index;
      b = req_byte_value;
      state_in = state_ff;   phase_in = phase_ff; mounted_in = mounted_ff;
      part_in = part_ff;     jump_in = jump_ff;   mbr_in = mbr_ff;
      bps_in = bps_ff;       spc_in = spc_ff;     rsv_in = rsv_ff;
      nfat_in = nfat_ff;     tsml_in = tsml_ff;   tlrg_in = tlrg_ff;
      fsml_in = fsml_ff;     flrg_in = flrg_ff;   root_in = root_ff;
      fat_in = fat_ff;       data_in = data_ff;   rts_in = rts_ff;
      meta_in = meta_ff;     wait_in = 1'b0;
      vld_in = 1'b0;         st_in = fvm_pkg::ST_OK;
      sec_in = 32'd0;        off_in = 16'd0;      nxt_in = 28'd0;
      op = '0;
      hj = (jump_ff == 8'hEB) || (jump_ff == 8'hE9);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_kind == fvm_pkg::KIND_BYTE) begin
                  mounted_in = 1'b0;
                  case (p)
                     9'h000: jump_in = b;
                     9'h00B: bps_in[7:0] = b;
                     9'h00C: bps_in[15:8] = b;
                     9'h00D: spc_in = b;
                     9'h00E: rsv_in[7:0] = b;
                     9'h00F: rsv_in[15:8] = b;
                     9'h010: nfat_in = b;
                     9'h013: tsml_in[7:0] = b;
                     9'h014: tsml_in[15:8] = b;
                     9'h016: fsml_in[7:0] = b;
                     9'h017: fsml_in[15:8] = b;
                     9'h020: tlrg_in[7:0] = b;
                     9'h021: tlrg_in[15:8] = b;
                     9'h022: tlrg_in[23:16] = b;
                     9'h023: tlrg_in[31:24] = b;
                     9'h024: flrg_in[7:0] = b;
                     9'h025: flrg_in[15:8] = b;
                     9'h026: flrg_in[23:16] = b;
                     9'h027: flrg_in[31:24] = b;
                     9'h02C: root_in[7:0] = b;
                     9'h02D: root_in[15:8] = b;
                     9'h02E: root_in[23:16] = b;
                     9'h02F: root_in[31:24] = b;
                     9'h1C6: mbr_in[7:0] = b;
                     9'h1C7: mbr_in[15:8] = b;
                     9'h1C8: mbr_in[23:16] = b;
                     9'h1C9: mbr_in[31:24] = b;
                     default: ;
                  endcase
                  // the end-of-sector decision uses the updated fields
                  if (req_last_byte) begin
                     hj = (jump_in == 8'hEB) || (jump_in == 8'hE9);
                     if (!phase_ff && !hj) begin
                        part_in = mbr_in;
                        phase_in = 1'b1;
                        vld_in = 1'b1;
                        st_in = fvm_pkg::ST_FEED;
                        sec_in = mbr_in;
                     end else begin
                        phase_in = 1'b0;
                        if (!phase_ff) part_in = 32'd0;
                        if (phase_ff && !hj) begin
                           vld_in = 1'b1;
                           st_in = fvm_pkg::ST_NO_BPB;
                        end else begin
                           // multiply fat copies by fat size
                           op.start = 1'b1;
                           op.is_div = 1'b0;
                           op.a = flrg_in;
                           op.b = {8'd0, nfat_in};
                           state_in = S_META;
                        end
                     end
                  end
               end else if (!mounted_ff) begin
                  vld_in = 1'b1;
                  st_in = fvm_pkg::ST_UNMOUNTED;
               end else if (req_kind == fvm_pkg::KIND_FIRST) begin
                  if (req_cluster_number == 28'd0) begin
                     vld_in = 1'b1;
                     sec_in = rts_ff;
                  end else begin
                     op.start = 1'b1;
                     op.a = {4'd0, req_cluster_number} - 32'd2;
                     op.b = {8'd0, spc_ff};
                     state_in = S_FIRST;
                  end
               end else if (req_kind == fvm_pkg::KIND_LOCATE) begin
                  if (bps_ff == 16'd0) begin
                     vld_in = 1'b1;
                     st_in = fvm_pkg::ST_ZERO_DIV;
                  end else begin
                     op.start = 1'b1;
                     op.is_div = 1'b1;
                     op.a = {2'd0, req_cluster_number, 2'd0};
                     op.b = bps_ff;
                     state_in = S_LOC;
                  end
               end else begin
                  vld_in = 1'b1;
                  nxt_in = req_fat_word[27:0];
               end
            end
         end
         S_META: begin
            wait_in = 1'b1;
            if (op_done) begin
               meta_in = {16'd0, rsv_ff} + op_q;
               if (fsml_ff != 16'd0) begin
                  vld_in = 1'b1; st_in = fvm_pkg::ST_FAT16_SZ; state_in = S_IDLE;
               end else if (spc_ff == 8'd0) begin
                  vld_in = 1'b1; st_in = fvm_pkg::ST_ZERO_DIV; state_in = S_IDLE;
               end else begin
                  op.start = 1'b1;
                  op.is_div = 1'b1;
                  op.a = total - ({16'd0, rsv_ff} + op_q);
                  op.b = {8'd0, spc_ff};
                  state_in = S_CNT;
               end
            end
         end
         S_CNT: begin
            wait_in = 1'b1;
            if (op_done) begin
               if (op_q < fvm_pkg::FAT12_LIMIT) begin
                  vld_in = 1'b1; st_in = fvm_pkg::ST_FAT12_CNT; state_in = S_IDLE;
               end else if (op_q < fvm_pkg::FAT16_LIMIT) begin
                  vld_in = 1'b1; st_in = fvm_pkg::ST_FAT16_CNT; state_in = S_IDLE;
               end else begin
                  op.start = 1'b1;
                  op.a = root_ff - 32'd2;
                  op.b = {8'd0, spc_ff};
                  state_in = S_ROOT;
               end
            end
         end
         S_ROOT: begin
            wait_in = 1'b1;
            if (op_done) begin
               fat_in = {16'd0, rsv_ff} + part_ff;
               data_in = data_off;
               rts_in = op_q + data_off;
               mounted_in = 1'b1;
               vld_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FIRST: begin
            wait_in = 1'b1;
            if (op_done) begin
               vld_in = 1'b1;
               sec_in = op_q + data_ff;
               state_in = S_IDLE;
            end
         end
         S_LOC: begin
            wait_in = 1'b1;
            if (op_done) begin
               vld_in = 1'b1;
               sec_in = fat_ff + op_q;
               off_in = op_r[15:0];
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; phase_ff <= 1'b0; mounted_ff <= 1'b0;
         part_ff <= '0; jump_ff <= '0; mbr_ff <= '0; bps_ff <= '0;
         spc_ff <= '0; rsv_ff <= '0; nfat_ff <= '0; tsml_ff <= '0;
         tlrg_ff <= '0; fsml_ff <= '0; flrg_ff <= '0; root_ff <= '0;
         fat_ff <= '0; data_ff <= '0; rts_ff <= '0; vld_ff <= 1'b0;
         wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in; phase_ff <= phase_in; mounted_ff <= mounted_in;
         part_ff <= part_in; jump_ff <= jump_in; mbr_ff <= mbr_in; bps_ff <= bps_in;
         spc_ff <= spc_in; rsv_ff <= rsv_in; nfat_ff <= nfat_in; tsml_ff <= tsml_in;
         tlrg_ff <= tlrg_in; fsml_ff <= fsml_in; flrg_ff <= flrg_in; root_ff <= root_in;
         fat_ff <= fat_in; data_ff <= data_in; rts_ff <= rts_in; vld_ff <= vld_in;
         wait_ff <= wait_in;
      end
      meta_ff <= meta_in;
      st_ff <= st_in; sec_ff <= sec_in; off_ff <= off_in; nxt_ff <= nxt_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = vld_ff;
   assign rsp_status = st_ff;
   assign rsp_sector_number = sec_ff;
   assign rsp_byte_offset = off_ff;
   assign rsp_start_of_fat = fat_ff;
   assign rsp_first_data_sector = data_ff;
   assign rsp_first_root_sector = rts_ff;
   assign rsp_sectors_per_cluster = spc_ff;
   assign rsp_bytes_per_sector = bps_ff;
   assign rsp_next_cluster = nxt_ff;

   a_mount_ok: assert property (@(posedge clock) disable iff (reset)
      $rose(mounted_ff) |-> rsp_valid && rsp_status == fvm_pkg::ST_OK)
      else $error("mount without ok result");
   a_unmount_on_byte: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_kind == fvm_pkg::KIND_BYTE |=> !mounted_ff)
      else $error("still mounted after sector byte");
   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      busy && !op_done |=> !rsp_valid)
      else $error("result while serial unit running");
   a_done_only_busy: assert property (@(posedge clock) disable iff (reset)
      op_done |-> busy)
      else $error("serial unit done while idle");
   a_wait_tracks: assert property (@(posedge clock) disable iff (reset)
      wait_ff |-> $past(busy))
      else $error("wait flag without busy");
endmodule

[test/fvm_checker.sv]
`timescale 1ns / 1ps
module fvm_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [8:0]  req_byte_index,
   input  logic [7:0]  req_byte_value,
   input  logic        req_last_byte,
   input  logic [27:0] req_cluster_number,
   input  logic [31:0] req_fat_word,
   input  logic        rsp_valid,
   input  logic [2:0]  rsp_status,
   input  logic [31:0] rsp_sector_number,
   input  logic [15:0] rsp_byte_offset,
   input  logic [31:0] rsp_start_of_fat,
   input  logic [31:0] rsp_first_data_sector,
   input  logic [31:0] rsp_first_root_sector,
   input  logic [7:0]  rsp_sectors_per_cluster,
   input  logic [15:0] rsp_bytes_per_sector,
   input  logic [27:0] rsp_next_cluster,
   output int          fail_count,
   output int          pending,
   output int          result_count
);
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] sector;
      logic [15:0] offset;
      logic [31:0] fat_start;
      logic [31:0] data_start;
      logic [31:0] root_start;
      logic [7:0]  spc;
      logic [15:0] bps;
      logic [27:0] next;
   } volume_reply_type;

   volume_reply_type replies_due[$];

   logic        mbr_phase;
   logic [31:0] part_base, mbr_lba, tot32, fatsz32, root_clus;
   logic [31:0] fat_lba, data_lba, root_lba;
   logic [15:0] bps, rsvd, tot16, fatsz16;
   logic [7:0]  jmp, spc, nfats;
   logic        is_mounted;

   assign pending = replies_due.size();

   function automatic logic [31:0] put_lane(logic [31:0] f, int pos, int base, int n,
                                            logic [7:0] b);
      if (pos >= base && pos < base + n) f[(pos - base) * 8 +: 8] = b;
      return f;
   endfunction

   // boot sector evaluation; updates start registers on success
   function automatic logic [2:0] mount_volume();
      logic [31:0] total, meta, count;
      if (fatsz16 != 0) return fvm_pkg::ST_FAT16_SZ;
      total = (tot16 != 0) ? 32'(tot16) : tot32;
      meta = 32'(rsvd) + 32'(nfats) * fatsz32;
      if (spc == 0) return fvm_pkg::ST_ZERO_DIV;
      count = (total - meta) / 32'(spc);
      if (count < fvm_pkg::FAT12_LIMIT) return fvm_pkg::ST_FAT12_CNT;
      if (count < fvm_pkg::FAT16_LIMIT) return fvm_pkg::ST_FAT16_CNT;
      fat_lba = 32'(rsvd) + part_base;
      data_lba = meta + part_base;
      root_lba = (root_clus - 32'd2) * 32'(spc) + data_lba;
      is_mounted = 1'b1;
      return fvm_pkg::ST_OK;
   endfunction

   task automatic predict_transfer();
      volume_reply_type r;
      int p;
      logic [31:0] foff;
      r = '0;
      p = int'(req_byte_index);
      if (req_kind == fvm_pkg::KIND_BYTE) begin
         is_mounted = 1'b0;
         jmp     = 8'(put_lane(32'(jmp), p, 'h00, 1, req_byte_value));
         bps     = 16'(put_lane(32'(bps), p, 'h0B, 2, req_byte_value));
         spc     = 8'(put_lane(32'(spc), p, 'h0D, 1, req_byte_value));
         rsvd    = 16'(put_lane(32'(rsvd), p, 'h0E, 2, req_byte_value));
         nfats   = 8'(put_lane(32'(nfats), p, 'h10, 1, req_byte_value));
         tot16   = 16'(put_lane(32'(tot16), p, 'h13, 2, req_byte_value));
         fatsz16 = 16'(put_lane(32'(fatsz16), p, 'h16, 2, req_byte_value));
         tot32   = put_lane(tot32, p, 'h20, 4, req_byte_value);
         fatsz32 = put_lane(fatsz32, p, 'h24, 4, req_byte_value);
         root_clus = put_lane(root_clus, p, 'h2C, 4, req_byte_value);
         mbr_lba = put_lane(mbr_lba, p, 'h1C6, 4, req_byte_value);
         if (!req_last_byte) return;
         if (!mbr_phase) begin
            if (jmp != 8'hEB && jmp != 8'hE9) begin
               part_base = mbr_lba;
               mbr_phase = 1'b1;
               r.status = fvm_pkg::ST_FEED;
               r.sector = part_base;
            end else begin
               part_base = '0;
               r.status = mount_volume();
            end
         end else begin
            mbr_phase = 1'b0;
            r.status = (jmp == 8'hEB || jmp == 8'hE9) ? mount_volume()
                                                      : fvm_pkg::ST_NO_BPB;
         end
      end else if (!is_mounted) begin
         r.status = fvm_pkg::ST_UNMOUNTED;
      end else if (req_kind == fvm_pkg::KIND_FIRST) begin
         r.sector = (req_cluster_number == 0) ? root_lba :
                    (32'(req_cluster_number) - 32'd2) * 32'(spc) + data_lba;
      end else if (req_kind == fvm_pkg::KIND_LOCATE) begin
         if (bps == 0) r.status = fvm_pkg::ST_ZERO_DIV;
         else begin
            foff = 32'(req_cluster_number) * 32'd4;
            r.sector = fat_lba + foff / 32'(bps);
            r.offset = 16'(foff % 32'(bps));
         end
      end else begin
         r.next = 28'(req_fat_word & fvm_pkg::ENTRY_MASK);
      end
      r.fat_start = fat_lba;
      r.data_start = data_lba;
      r.root_start = root_lba;
      r.spc = spc;
      r.bps = bps;
      replies_due.push_back(r);
   endtask

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch expected %h actual %h", $realtime, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      volume_reply_type e;
      if (reset) begin
         mbr_phase = 0; part_base = 0; mbr_lba = 0; tot32 = 0; fatsz32 = 0;
         root_clus = 0; fat_lba = 0; data_lba = 0; root_lba = 0; bps = 0;
         rsvd = 0; tot16 = 0; fatsz16 = 0; jmp = 0; spc = 0; nfats = 0;
         is_mounted = 0;
         fail_count = 0;
         result_count = 0;
      end else begin
         // a result never shows in the cycle its own request transfers
         if (rsp_valid) begin
            result_count++;
            if (replies_due.size() == 0) begin
               $display("%0t: unexpected transfer status %0d", $realtime, rsp_status);
               fail_count++;
            end else begin
               e = replies_due.pop_front();
               check_field("status", 32'(e.status), 32'(rsp_status));
               check_field("sector_number", e.sector, rsp_sector_number);
               check_field("byte_offset", 32'(e.offset), 32'(rsp_byte_offset));
               check_field("start_of_fat", e.fat_start, rsp_start_of_fat);
               check_field("first_data_sector", e.data_start, rsp_first_data_sector);
               check_field("first_root_sector", e.root_start, rsp_first_root_sector);
               check_field("sectors_per_cluster", 32'(e.spc), 32'(rsp_sectors_per_cluster));
               check_field("bytes_per_sector", 32'(e.bps), 32'(rsp_bytes_per_sector));
               check_field("next_cluster", 32'(e.next), 32'(rsp_next_cluster));
            end
         end
         if (start && !busy) predict_transfer();
      end
   end
endmodule

[test/tb.sv]
`timescale 1ns / 1ps
module tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_kind = fvm_pkg::KIND_BYTE;
   logic [8:0]  req_byte_index = 0;
   logic [7:0]  req_byte_value = 0;
   logic        req_last_byte = 0;
   logic [27:0] req_cluster_number = 0;
   logic [31:0] req_fat_word = 0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_sector_number, rsp_start_of_fat, rsp_first_data_sector;
   logic [31:0] rsp_first_root_sector;
   logic [15:0] rsp_byte_offset, rsp_bytes_per_sector;
   logic [7:0]  rsp_sectors_per_cluster;
   logic [27:0] rsp_next_cluster;
   int fail_count, pending, result_count;
   int cycles = 0, sectors_fed = 0, queries = 0, items = 0;

   localparam int CYCLE_LIMIT = 2_000_000;

   always #2 clock = ~clock;

   fat32_volume_mount_and_cluster_map u_dut (.*);

   fvm_checker u_chk (.*);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout at cycle %0d", cycles);
         $display("fat32_volume_mount_and_cluster_map verification failed");
         $finish;
      end
   end

   // present one item and hold until the transfer, then the given gap
   task automatic send_item(logic [1:0] k, logic [8:0] idx, logic [7:0] v, logic lst,
                            logic [27:0] clus, logic [31:0] w, int gap);
      int n;
      start <= 1'b1;
      req_kind <= k;
      req_byte_index <= idx;
      req_byte_value <= v;
      req_last_byte <= lst;
      req_cluster_number <= clus;
      req_fat_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      items++;
      if (gap > 0) begin
         start <= 1'b0;
         for (n = 0; n < gap; n++) @(posedge clock);
      end
   endtask

   function automatic int rgap();
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
   endfunction

   // sector image: boot sector with chosen geometry, or MBR pointing at part
   task automatic feed_sector(bit mbr, logic [31:0] part, logic [7:0] spc,
                              logic [15:0] bps, logic [15:0] rsvd, logic [7:0] nf,
                              logic [15:0] t16, logic [31:0] t32, logic [15:0] f16,
                              logic [31:0] f32, logic [31:0] rootc, bit noise, int len);
      logic [7:0] img [512];
      int i;
      foreach (img[i]) img[i] = noise ? 8'($urandom) : 8'h00;
      if (mbr) begin
         img[0] = noise ? 8'($urandom_range(0, 232)) : 8'h33;
         {img['h1C9], img['h1C8], img['h1C7], img['h1C6]} = part;
      end else begin
         img[0] = $urandom_range(0, 1) ? 8'hEB : 8'hE9;
         {img['h0C], img['h0B]} = bps;
         img['h0D] = spc;
         {img['h0F], img['h0E]} = rsvd;
         img['h10] = nf;
         {img['h14], img['h13]} = t16;
         {img['h17], img['h16]} = f16;
         {img['h23], img['h22], img['h21], img['h20]} = t32;
         {img['h27], img['h26], img['h25], img['h24]} = f32;
         {img['h2F], img['h2E], img['h2D], img['h2C]} = rootc;
      end
      sectors_fed++;
      // only the captured header and MBR entry matter; short sectors end early
      for (i = 0; i < len; i++)
         send_item(fvm_pkg::KIND_BYTE, 9'(i), img[i], i == len - 1, 0, 0,
                   $urandom_range(0, 7) == 0 ? rgap() : 0);
   endtask

   task automatic run_queries(int n);
      int i;
      logic [1:0] k;
      logic [27:0] c;
      for (i = 0; i < n; i++) begin
         k = 2'($urandom_range(1, 3));
         case ($urandom_range(0, 3))
            0: c = 0;
            1: c = 28'($urandom_range(1, 3));
            2: c = 28'hFFF_FFFF;
            default: c = 28'($urandom);
         endcase
         queries++;
         send_item(k, 9'($urandom), 8'($urandom), 1'($urandom), c, $urandom, rgap());
      end
   endtask

   task automatic random_volume();
      logic [7:0] spc;
      logic [15:0] bps;
      logic [31:0] part, t32;
      int sel, len;
      spc = ($urandom_range(0, 9) == 0) ? 8'(0) : 8'(1 << $urandom_range(0, 7));
      if ($urandom_range(0, 5) == 0) spc = 8'($urandom);
      bps = ($urandom_range(0, 9) == 0) ? 16'(0) : 16'(512 << $urandom_range(0, 3));
      if ($urandom_range(0, 7) == 0) bps = 16'($urandom);
      part = $urandom;
      t32 = $urandom;
      sel = $urandom_range(0, 9);
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 512) : 48;
      // a short MBR keeps the partition start captured earlier
      if (sel < 3)
         feed_sector(1, part, 0, 0, 0, 0, 0, 0, 0, 0, 0, $urandom_range(0, 1), len);
      if (sel == 9)
         feed_sector(1, part, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, len);
      else
         feed_sector(0, 0, spc, bps, 16'($urandom), 8'($urandom_range(0, 3)),
                     ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'(0), t32,
                     ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'(0),
                     32'($urandom_range(0, 1 << 16)), $urandom,
                     $urandom_range(0, 5) == 0, len);
      run_queries($urandom_range(5, 40));
   endtask

   initial begin
      int i;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // queries with nothing mounted
      send_item(fvm_pkg::KIND_FIRST, 0, 0, 0, 0, 0, 0);
      send_item(fvm_pkg::KIND_LOCATE, 0, 0, 0, 28'hFFF_FFFF, 0, 1);
      send_item(fvm_pkg::KIND_DECODE, 9'h1FF, 8'hFF, 1, 0, 32'hFFFF_FFFF, 0);
      // MBR then a good FAT32 partition
      feed_sector(1, 32'h0000_0800, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 512);
      feed_sector(0, 0, 8, 512, 32, 2, 0, 32'h0100_0000, 0, 32'h3FFF, 2, 0, 48);
      send_item(fvm_pkg::KIND_FIRST, 0, 0, 0, 0, 0, 0);
      send_item(fvm_pkg::KIND_FIRST, 0, 0, 0, 1, 0, 0);
      send_item(fvm_pkg::KIND_FIRST, 0, 0, 0, 28'hFFF_FFFF, 0, 0);
      send_item(fvm_pkg::KIND_LOCATE, 0, 0, 0, 28'hFFF_FFFF, 0, 0);
      send_item(fvm_pkg::KIND_DECODE, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
      // MBR whose partition has no jump byte
      feed_sector(1, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 460);
      feed_sector(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 48);
      // FAT16 size, zero spc, FAT12 and FAT16 counts, wrap, zero bps
      feed_sector(0, 0, 8, 512, 1, 2, 0, 32'h100000, 16'hFFFF, 0, 2, 0, 48);
      feed_sector(0, 0, 0, 512, 1, 2, 0, 32'h100000, 0, 8, 2, 0, 48);
      feed_sector(0, 0, 1, 512, 0, 0, 4084, 0, 0, 0, 2, 0, 48);
      feed_sector(0, 0, 1, 512, 0, 0, 16'hFFF4, 0, 0, 0, 2, 0, 48);
      feed_sector(0, 0, 8'hFF, 0, 16'hFFFF, 8'hFF, 0, 0, 0, 32'h1, 0, 0, 48);
      send_item(fvm_pkg::KIND_LOCATE, 0, 0, 0, 5, 0, 0);
      send_item(fvm_pkg::KIND_FIRST, 0, 0, 0, 0, 0, 0);
      send_item(fvm_pkg::KIND_BYTE, 9'd3, 8'h00, 0, 0, 0, 0);
      send_item(fvm_pkg::KIND_DECODE, 0, 0, 0, 0, 32'h1234_5678, 0);
      // random volumes with queries
      i = 0;
      while (items < 2000) begin
         random_volume();
         i++;
      end
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("%0d items in %0d sectors and %0d queries sent, %0d results checked",
               items, sectors_fed, queries, result_count);
      $display("covered MBR and direct boot sectors, every mount outcome and all query kinds");
      if (fail_count == 0)
         $display("fat32_volume_mount_and_cluster_map verification clean");
      else
         $display("fat32_volume_mount_and_cluster_map verification failed");
      $finish;
   end
endmodule

[sim.f]
src/fvm_pkg.sv
src/fvm_serial_unit.sv
src/fat32_volume_mount_and_cluster_map.sv
test/fvm_checker.sv
test/tb.sv
